// ----- design/ppd_pkg.sv -----
package ppd_pkg;

  localparam logic [7:0] CharP    = 8'h50;
  localparam logic [7:0] Char3    = 8'h33;
  localparam logic [7:0] CharHash = 8'h23;
  localparam logic [7:0] CharLf   = 8'h0a;
  localparam logic [7:0] Char0    = 8'h30;
  localparam logic [7:0] Char9    = 8'h39;

  localparam logic [15:0] AccMax     = 16'hffff;
  localparam logic [15:0] MaxValue   = 16'd255;
  localparam logic [7:0]  ChannelMax = 8'd255;

  localparam logic       CfgScreenWidth = 1'b0;
  localparam logic       CfgRowOffset   = 1'b1;
  localparam logic [12:0] ScreenWidthRst = 13'd1024;
  localparam logic [11:0] RowOffsetRst   = 12'd128;

  typedef enum logic [1:0] {
    RK_PIXEL     = 2'd0,
    RK_BAD_MAGIC = 2'd1,
    RK_BAD_MAX   = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    TK_NONE      = 2'd0,
    TK_NUM       = 2'd1,
    TK_MAGIC_ERR = 2'd2
  } tok_kind_e;

  typedef struct packed {
    logic      sof;
    tok_kind_e kind;
    logic [15:0] value;
  } tok_t;

endpackage

// ----- design/ascii_ppm_pixel_decoder.sv -----
// Parses an ASCII PPM (P3) file fed one byte per item and emits one item per
// pixel with its screen position and 24-bit color, or one error item for a bad
// magic or a maximum value other than 255. A byte is taken every cycle; the
// front end tokenizes numbers and passes them through a two-entry queue to the
// back end, so a result passes through the queue and then the output register after
// the byte that ends its last number, and the input stalls only when the queue fills behind a stalled output.
module ascii_ppm_pixel_decoder import ppd_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic signed [13:0] screen_x_o,
  output logic [12:0] screen_y_o,
  output logic [23:0] pixel_color_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  logic [12:0] screen_width_q;
  logic [11:0] row_offset_q;
  logic        push, full, pop, fifo_valid;
  tok_t        push_tok, pop_tok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q <= ScreenWidthRst;
      row_offset_q   <= RowOffsetRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgScreenWidth: screen_width_q <= cfg_data_i;
        CfgRowOffset:   row_offset_q   <= cfg_data_i[11:0];
        default:        ;
      endcase
    end
  end

  ppd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .start_of_file_i (start_of_file_i),
    .tok_valid_o     (push),
    .tok_full_i      (full),
    .tok_o           (push_tok)
  );

  ppd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_tok),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (pop_tok)
  );

  ppd_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_valid_i    (fifo_valid),
    .tok_i          (pop_tok),
    .tok_pop_o      (pop),
    .screen_width_i (screen_width_q),
    .row_offset_i   (row_offset_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .pixel_color_o  (pixel_color_o)
  );

endmodule

// ----- design/ppd_front.sv -----
module ppd_front import ppd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_file_i,
  output logic       tok_valid_o,
  input  logic       tok_full_i,
  output tok_t       tok_o
);

  logic [1:0]  byte_pos_q, byte_pos_d;
  logic        halted_q, halted_d;
  logic        in_comment_q, in_comment_d;
  logic        in_number_q, in_number_d;
  logic [15:0] acc_q, acc_d;
  logic        accept;
  logic [19:0] prod;
  tok_kind_e   kind;

  assign in_stall_o = tok_full_i;
  assign accept     = in_valid_i && !tok_full_i;

  always_comb begin
    byte_pos_d   = byte_pos_q;
    halted_d     = halted_q;
    in_comment_d = in_comment_q;
    in_number_d  = in_number_q;
    acc_d        = acc_q;
    kind         = TK_NONE;
    prod         = '0;
    if (start_of_file_i) begin
      byte_pos_d   = '0;
      halted_d     = 1'b0;
      in_comment_d = 1'b0;
      in_number_d  = 1'b0;
      acc_d        = '0;
    end
    if (!halted_d) begin
      if (byte_pos_d != 2'd3) begin
        if ((byte_pos_d == 2'd0 && data_byte_i != CharP) ||
            (byte_pos_d == 2'd1 && data_byte_i != Char3)) begin
          kind     = TK_MAGIC_ERR;
          halted_d = 1'b1;
        end
        byte_pos_d = byte_pos_d + 2'd1;
      end else if (in_comment_d) begin
        if (data_byte_i == CharLf) begin
          in_comment_d = 1'b0;
        end
      end else if (data_byte_i == CharHash) begin
        in_comment_d = 1'b1;
      end else if (data_byte_i >= Char0 && data_byte_i <= Char9) begin
        prod        = {4'd0, acc_d} * 20'd10 + {12'd0, data_byte_i - Char0};
        acc_d       = (prod > {4'd0, AccMax}) ? AccMax : prod[15:0];
        in_number_d = 1'b1;
      end else if (in_number_d) begin
        kind        = TK_NUM;
        in_number_d = 1'b0;
        acc_d       = '0;
      end
    end
  end

  assign tok_valid_o = accept && (start_of_file_i || kind != TK_NONE);
  assign tok_o.sof   = start_of_file_i;
  assign tok_o.kind  = kind;
  assign tok_o.value = start_of_file_i ? 16'd0 : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= '0;
      halted_q     <= 1'b0;
      in_comment_q <= 1'b0;
      in_number_q  <= 1'b0;
      acc_q        <= '0;
    end else if (accept) begin
      byte_pos_q   <= byte_pos_d;
      halted_q     <= halted_d;
      in_comment_q <= in_comment_d;
      in_number_q  <= in_number_d;
      acc_q        <= acc_d;
    end
  end

endmodule

// ----- design/ppd_fifo.sv -----
module ppd_fifo import ppd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tok_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output tok_t pop_data_o
);

  tok_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = count_q == 2'd2;
  assign valid_o    = count_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ----- design/ppd_back.sv -----
module ppd_back import ppd_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         tok_valid_i,
  input  tok_t         tok_i,
  output logic         tok_pop_o,
  input  logic [12:0]  screen_width_i,
  input  logic [11:0]  row_offset_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [1:0]   result_kind_o,
  output logic signed [13:0] screen_x_o,
  output logic [12:0]  screen_y_o,
  output logic [23:0]  pixel_color_o
);

  localparam logic [12:0] DimLim = 13'(MAX_DIM);

  logic        halted_q, halted_d;
  logic [12:0] width_q, width_d;
  logic [12:0] height_q, height_d;
  logic        max_ok_q, max_ok_d;
  logic [1:0]  chan_q, chan_d;
  logic [23:0] color_q, color_d;
  logic [12:0] col_q, col_d;
  logic [12:0] row_q, row_d;

  logic         out_valid_q, out_valid_d;
  result_kind_e kind_q, kind_d;
  logic [13:0]  sx_q, sx_d;
  logic [12:0]  sy_q, sy_d;
  logic [23:0]  pix_q, pix_d;

  logic [12:0] dim;
  logic [7:0]  chan_val;
  logic [12:0] col_inc;

  assign tok_pop_o = tok_valid_i && (!out_valid_q || !out_stall_i);
  assign dim       = (tok_i.value > {3'd0, DimLim}) ? DimLim : tok_i.value[12:0];
  assign chan_val  = (tok_i.value > MaxValue) ? ChannelMax : tok_i.value[7:0];

  always_comb begin
    halted_d    = halted_q;
    width_d     = width_q;
    height_d    = height_q;
    max_ok_d    = max_ok_q;
    chan_d      = chan_q;
    color_d     = color_q;
    col_d       = col_q;
    row_d       = row_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    pix_d       = pix_q;
    col_inc     = '0;
    if (tok_pop_o) begin
      if (tok_i.sof) begin
        halted_d = 1'b0;
        width_d  = '0;
        height_d = '0;
        max_ok_d = 1'b0;
        chan_d   = '0;
        color_d  = '0;
        col_d    = '0;
        row_d    = '0;
      end
      if (tok_i.kind == TK_MAGIC_ERR) begin
        halted_d    = 1'b1;
        out_valid_d = 1'b1;
        kind_d      = RK_BAD_MAGIC;
        sx_d        = '0;
        sy_d        = '0;
        pix_d       = '0;
      end else if (tok_i.kind == TK_NUM && !halted_d) begin
        if (width_d == '0) begin
          width_d = dim;
        end else if (height_d == '0) begin
          height_d = dim;
        end else if (!max_ok_d) begin
          if (tok_i.value == MaxValue) begin
            max_ok_d = 1'b1;
          end else begin
            halted_d    = 1'b1;
            out_valid_d = 1'b1;
            kind_d      = RK_BAD_MAX;
            sx_d        = '0;
            sy_d        = '0;
            pix_d       = '0;
          end
        end else begin
          color_d = {color_d[15:0], chan_val};
          chan_d  = chan_d + 2'd1;
          if (chan_d == 2'd3) begin
            chan_d      = '0;
            out_valid_d = 1'b1;
            kind_d      = RK_PIXEL;
            sx_d        = {1'b0, screen_width_i} - {1'b0, width_d} + {1'b0, col_d};
            sy_d        = row_d + {1'b0, row_offset_i};
            pix_d       = color_d;
            col_inc     = col_d + 13'd1;
            if (col_inc >= width_d) begin
              col_d = '0;
              row_d = row_d + 13'd1;
            end else begin
              col_d = col_inc;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q    <= 1'b0;
      width_q     <= '0;
      height_q    <= '0;
      max_ok_q    <= 1'b0;
      chan_q      <= '0;
      color_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      halted_q    <= halted_d;
      width_q     <= width_d;
      height_q    <= height_d;
      max_ok_q    <= max_ok_d;
      chan_q      <= chan_d;
      color_q     <= color_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    pix_q  <= pix_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign screen_x_o    = sx_q;
  assign screen_y_o    = sy_q;
  assign pixel_color_o = pix_q;

endmodule

// ----- dv/ppm_pixel_checker.sv -----
module ppm_pixel_checker import ppd_pkg::*; #(
  parameter int MaxDim = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  result_kind_i,
  input  logic [13:0] screen_x_i,
  input  logic [12:0] screen_y_i,
  input  logic [23:0] pixel_color_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  output int          error_count_o,
  output int          pending_o
);

  typedef struct packed {
    result_kind_e kind;
    logic [13:0]  x;
    logic [12:0]  y;
    logic [23:0]  color;
  } screen_item_t;

  screen_item_t expected_q[$];

  logic [12:0] screen_w;
  logic [11:0] row_off;

  logic [1:0]  byte_pos;
  logic        halted;
  logic        in_comment;
  logic        in_number;
  logic [15:0] acc;
  logic [12:0] img_w;
  logic [12:0] img_h;
  logic [15:0] max_seen;
  logic [1:0]  chan;
  logic [23:0] color;
  logic [12:0] col;
  logic [12:0] row;

  task automatic clear_parse();
    byte_pos   = '0;
    halted     = 1'b0;
    in_comment = 1'b0;
    in_number  = 1'b0;
    acc        = '0;
    img_w      = '0;
    img_h      = '0;
    max_seen   = '0;
    chan       = '0;
    color      = '0;
    col        = '0;
    row        = '0;
  endtask

  function automatic logic [12:0] clamp_dim(logic [15:0] v);
    return (v > MaxDim) ? 13'(MaxDim) : v[12:0];
  endfunction

  task automatic push_error(result_kind_e kind);
    screen_item_t err;
    err.kind  = kind;
    err.x     = '0;
    err.y     = '0;
    err.color = '0;
    halted = 1'b1;
    expected_q.push_back(err);
  endtask

  task automatic note_failure(string msg);
    if (error_count_o < 10) begin
      $display("%0t: %s", $time, msg);
    end
    error_count_o++;
  endtask

  task automatic decode_byte(logic [7:0] c, logic sof);
    int unsigned acc_next;
    logic [15:0] num;
    logic [1:0]  pos;
    screen_item_t pix;
    if (sof) begin
      clear_parse();
    end
    if (halted) begin
      return;
    end
    if (byte_pos < 2'd3) begin
      pos = byte_pos;
      byte_pos = pos + 2'd1;
      if ((pos == 2'd0 && c != CharP) || (pos == 2'd1 && c != Char3)) begin
        push_error(RK_BAD_MAGIC);
      end
      return;
    end
    if (in_comment) begin
      if (c == CharLf) begin
        in_comment = 1'b0;
      end
      return;
    end
    if (c == CharHash) begin
      in_comment = 1'b1;
      return;
    end
    if (c >= Char0 && c <= Char9) begin
      acc_next = acc * 10 + (c - Char0);
      acc = (acc_next > AccMax) ? AccMax : acc_next[15:0];
      in_number = 1'b1;
      return;
    end
    if (!in_number) begin
      return;
    end
    in_number = 1'b0;
    num = acc;
    acc = '0;
    if (img_w == '0) begin
      img_w = clamp_dim(num);
      return;
    end
    if (img_h == '0) begin
      img_h = clamp_dim(num);
      return;
    end
    if (max_seen == '0) begin
      max_seen = num;
      if (num != MaxValue) begin
        push_error(RK_BAD_MAX);
      end
      return;
    end
    if (num > 16'(ChannelMax)) begin
      num = 16'(ChannelMax);
    end
    color = {color[15:0], num[7:0]};
    chan = chan + 2'd1;
    if (chan < 2'd3) begin
      return;
    end
    chan = '0;
    pix.kind  = RK_PIXEL;
    pix.x     = {1'b0, screen_w} - {1'b0, img_w} + {1'b0, col};
    pix.y     = row + 13'(row_off);
    pix.color = color;
    expected_q.push_back(pix);
    col = col + 13'd1;
    if (col >= img_w) begin
      col = '0;
      row = row + 13'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    screen_item_t want;
    if (!rst_ni) begin
      screen_w = ScreenWidthRst;
      row_off  = RowOffsetRst;
      clear_parse();
      expected_q.delete();
    end else begin
      // Results are taken before this edge's byte, which cannot produce one yet.
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result: kind %0d x %0d y %0d color %06h",
                                 result_kind_i, $signed(screen_x_i), screen_y_i,
                                 pixel_color_i));
        end else begin
          want = expected_q.pop_front();
          if (result_kind_i !== want.kind || screen_x_i !== want.x ||
              screen_y_i !== want.y || pixel_color_i !== want.color) begin
            note_failure($sformatf({"mismatch: expected kind %0d x %0d y %0d color %06h,",
                                    " got kind %0d x %0d y %0d color %06h"},
                                   want.kind, $signed(want.x), want.y, want.color,
                                   result_kind_i, $signed(screen_x_i), screen_y_i,
                                   pixel_color_i));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgScreenWidth) begin
          screen_w = cfg_data_i;
        end else begin
          row_off = cfg_data_i[11:0];
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(data_byte_i, start_of_file_i);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ----- dv/testbench.sv -----
module testbench import ppd_pkg::*;;

  localparam int MaxDim      = 4096;
  localparam int CycleLimit  = 300000;
  localparam int PhaseItems  = 80;
  localparam int NumPhases   = 5;
  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic       sof;
    logic [7:0] data;
  } file_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         data_byte_i;
  logic               start_of_file_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         result_kind_o;
  logic signed [13:0] screen_x_o;
  logic [12:0]        screen_y_o;
  logic [23:0]        pixel_color_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [12:0]        cfg_data_i;

  int   error_count;
  int   pending;
  int   cycle_count;
  logic idle_on;
  logic hold_off_req;

  file_byte_t stream_q[$];

  always #5 clk_i = ~clk_i;

  ascii_ppm_pixel_decoder #(
    .MAX_DIM(MaxDim)
  ) i_dut (.*);

  ppm_pixel_checker #(
    .MaxDim(MaxDim)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i     (in_stall_o),
    .data_byte_i,
    .start_of_file_i,
    .out_valid_i    (out_valid_o),
    .out_stall_i,
    .result_kind_i  (result_kind_o),
    .screen_x_i     (screen_x_o),
    .screen_y_i     (screen_y_o),
    .pixel_color_i  (pixel_color_o),
    .cfg_valid_i,
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .error_count_o  (error_count),
    .pending_o      (pending)
  );

  function automatic void put(logic [7:0] b, logic sof = 1'b0);
    file_byte_t fb;
    fb.sof  = sof;
    fb.data = b;
    stream_q.push_back(fb);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      put(s[i]);
    end
  endfunction

  function automatic void put_comment();
    logic [7:0] b;
    put(CharHash);
    repeat ($urandom_range(0, 4)) begin
      b = 8'($urandom_range(0, 255));
      put((b == CharLf) ? CharHash : b);
    end
    put(CharLf);
  endfunction

  // A comment alone would join two numbers, so a real separator always comes first.
  function automatic void put_gap();
    string blanks = " \t\r\n";
    logic [7:0] b;
    if ($urandom_range(0, 99) < 75) begin
      b = blanks[$urandom_range(0, 3)];
    end else begin
      b = 8'($urandom_range(0, 255));
      while ((b >= Char0 && b <= Char9) || b == CharHash) begin
        b = 8'($urandom_range(0, 255));
      end
    end
    put(b);
    if ($urandom_range(0, 9) == 0) begin
      put_comment();
    end
  endfunction

  function automatic void put_number(int unsigned v);
    string digits = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) begin
      digits = {"00", digits};
    end
    for (int i = 0; i < digits.len(); i++) begin
      put(digits[i]);
      if (i + 1 < digits.len() && $urandom_range(0, 19) == 0) begin
        put_comment();
      end
    end
  endfunction

  function automatic void put_junk();
    repeat ($urandom_range(1, 6)) begin
      put(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic int unsigned pick_dim();
    int r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 4);
    end
    if (r < 95) begin
      return $urandom_range(5, 40);
    end
    return $urandom_range(4000, 99999);
  endfunction

  function automatic void put_file();
    int          r = $urandom_range(0, 99);
    int unsigned top_value;
    int unsigned pixels;
    logic [7:0]  b;
    if (r < 5) begin
      b = 8'($urandom_range(0, 255));
      while (b == CharP) begin
        b = 8'($urandom_range(0, 255));
      end
      put(b, 1'b1);
      put_junk();
      return;
    end
    put(CharP, 1'b1);
    if (r < 10) begin
      b = 8'($urandom_range(0, 255));
      while (b == Char3) begin
        b = 8'($urandom_range(0, 255));
      end
      put(b);
      put_junk();
      return;
    end
    put(Char3);
    put(8'($urandom_range(0, 255)));
    for (int d = 0; d < 2; d++) begin
      if ($urandom_range(0, 9) == 0) begin
        put_number(0);
        put_gap();
      end
      put_number(pick_dim());
      put_gap();
    end
    top_value = MaxValue;
    if (r >= 85) begin
      case ($urandom_range(0, 3))
        0: top_value = 0;
        1: top_value = 254;
        2: top_value = 256;
        default: top_value = $urandom_range(0, 99999);
      endcase
    end
    put_number(top_value);
    put_gap();
    if (top_value != MaxValue) begin
      put_junk();
      return;
    end
    pixels = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
    repeat (pixels * 3) begin
      put_number(($urandom_range(0, 9) == 0) ? $urandom_range(256, 99999)
                                              : $urandom_range(0, 255));
      put_gap();
    end
    r = $urandom_range(0, 9);
    if (r < 2) begin
      put_number($urandom_range(0, 999));
    end else if (r == 2) begin
      put_number($urandom_range(0, 255));
      put_gap();
    end
  endfunction

  task automatic send_stream();
    file_byte_t item;
    while (stream_q.size() > 0) begin
      item = stream_q.pop_front();
      while (idle_on && $urandom_range(0, 99) < 28) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
      in_valid_i      = 1'b1;
      data_byte_i     = item.data;
      start_of_file_i = item.sof;
      do @(posedge clk_i); while (in_stall_o);
      @(negedge clk_i);
    end
    in_valid_i = 1'b0;
  endtask

  task automatic settle();
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [12:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : receiver
    int  hold_cycles;
    logic hold_done;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done   = 1'b1;
        hold_cycles = 0;
        out_stall_i = 1'b1;
        while (hold_cycles < HoldCycles) begin
          @(negedge clk_i);
          hold_cycles++;
        end
      end
      out_stall_i = idle_on && ($urandom_range(0, 99) < 28);
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    start_of_file_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CfgScreenWidth;
    cfg_data_i      = '0;
    idle_on         = 1'b1;
    hold_off_req    = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        settle();
      end
      case (phase)
        0: ;
        1: begin
          write_reg(CfgScreenWidth, 13'd0);
          write_reg(CfgRowOffset, 13'd0);
        end
        2: begin
          write_reg(CfgRowOffset, 13'h1fff);
          write_reg(CfgScreenWidth, 13'h1fff);
        end
        default: begin
          write_reg(CfgScreenWidth, 13'($urandom_range(0, 8191)));
          write_reg(CfgRowOffset, 13'($urandom_range(0, 8191)));
        end
      endcase
      idle_on = (phase != 2);
      if (phase == 0) begin
        // A file without a start mark, then both magic failures, then a zero maximum
        // followed by a byte that must be ignored.
        put_text("P3 1 1 255 0 255 7 ");
        put(8'h00, 1'b1);
        put(CharP, 1'b1);
        put(8'hff);
        put(CharP, 1'b1);
        put_text("3 1 1 0 ");
        put(Char9);
      end
      if (phase == 1) begin
        hold_off_req = 1'b1;
      end
      while (stream_q.size() < PhaseItems) begin
        put_file();
      end
      send_stream();
    end

    settle();
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
